// ----- hdl/sdfe_pkg.sv -----
package sdfe_pkg;

  localparam int ScoreW  = 16;
  localparam int ModeW   = 2;
  localparam int TimerW  = 9;
  localparam int ShownW  = 10;
  localparam int SegW    = 8;
  localparam int WordW   = 16;
  localparam int PeriodW = 8;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 8;

  localparam int InDataW  = 40;
  localparam int OutDataW = 48;

  localparam logic [TimerW-1:0] TIMER_MAX   = 9'd511;
  localparam logic [ShownW-1:0] SCORE_MAX   = 10'd999;
  localparam logic [ShownW-1:0] BLANK_CODE  = 10'd1000;
  localparam logic [PeriodW-1:0] FLASH_RST  = 8'd25;
  localparam logic [PeriodW-1:0] UPDATE_RST = 8'd1;

  localparam logic [CfgIdxW-1:0] CFG_ENABLE        = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FLASH_PERIOD  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_UPDATE_PERIOD = 2'd2;

  typedef enum logic [ModeW-1:0] {
    MODE_NORMAL = 2'd0,
    MODE_FLASH  = 2'd1,
    MODE_BLANK  = 2'd2,
    MODE_ALT    = 2'd3
  } mode_t;

  typedef struct packed {
    logic [SegW-1:0] hund;
    logic [SegW-1:0] tens;
    logic [SegW-1:0] ones;
  } seg3_t;

  typedef struct packed {
    logic [TimerW-1:0] timer;
    logic              phase;
    logic [ShownW-1:0] shown;
  } player_t;

endpackage

// ----- hdl/score_display_flash_encoder_top.sv -----
// Score display encoder. Each request carries both raw scores, a display mode per
// player and a flash sync flag; a frame of three seven-segment words comes out when
// the send timer runs past update_period while enable is set. The block takes one
// request per clock cycle unless a stalled frame holds it back: a request is captured
// in an input register, and the timer, flash and clamp logic plus the decimal split
// load the result register from it once that register is free or being taken.
// The result register alone limits throughput: a frame that is not taken stalls the
// next request only once the input register also holds one. Configuration writes
// take effect at the next clock edge and should be issued while the block is idle.
module score_display_flash_encoder_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sdfe_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [sdfe_pkg::CfgW-1:0]     cfg_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [15:0] player_one_score, [31:16] player_two_score, [33:32] player_one_mode,
  // [35:34] player_two_mode, [36] sync_flash, [39:37] zero
  input  logic [sdfe_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [15:0] left_word, [31:16] middle_word, [47:32] right_word
  output logic [sdfe_pkg::OutDataW-1:0] m_axis_tdata
);
  import sdfe_pkg::*;

  localparam logic [SegW-1:0] SEG_DIGIT [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  function automatic seg3_t encode3(input logic [ShownW-1:0] v);
    logic [15:0]       hprod;
    logic [3:0]        h;
    logic [6:0]        r;
    logic [13:0]       tprod;
    logic [3:0]        t;
    logic [3:0]        o;
    logic [ShownW-1:0] hx;
    logic [6:0]        tx;
    seg3_t             e;
    hprod = 16'(v) * 16'd41;
    h     = hprod[15:12];
    hx    = {6'b0, h} * 10'd100;
    r     = 7'(v - hx);
    tprod = 14'(r) * 14'd103;
    t     = tprod[13:10];
    tx    = {3'b0, t} * 7'd10;
    o     = 4'(r - tx);
    if (v > SCORE_MAX) begin
      e = '0;
    end else begin
      e.ones = SEG_DIGIT[o];
      e.tens = SEG_DIGIT[t];
      e.hund = SEG_DIGIT[h];
      if (h == 4'd0) begin
        e.hund = '0;
        if (t == 4'd0) begin
          e.tens = '0;
        end
      end
    end
    return e;
  endfunction

  function automatic player_t player_update(
    input logic [ModeW-1:0]   mode,
    input logic [ScoreW-1:0]  score,
    input logic [TimerW-1:0]  timer,
    input logic               phase,
    input logic [ShownW-1:0]  shown,
    input logic [PeriodW-1:0] period
  );
    player_t p;
    p.timer = timer;
    p.phase = phase;
    p.shown = shown;
    case (mode_t'(mode))
      MODE_FLASH: begin
        if (timer > {1'b0, period}) begin
          p.timer = '0;
          if (!phase) begin
            p.phase = 1'b1;
            p.shown = (score > ScoreW'(SCORE_MAX)) ? BLANK_CODE : score[ShownW-1:0];
          end else begin
            p.phase = 1'b0;
            p.shown = BLANK_CODE;
          end
        end
      end
      MODE_BLANK: begin
        p.shown = BLANK_CODE;
      end
      default: begin
        p.shown = (score > ScoreW'(SCORE_MAX)) ? SCORE_MAX : score[ShownW-1:0];
      end
    endcase
    return p;
  endfunction

  function automatic logic [TimerW-1:0] tick(input logic [TimerW-1:0] t);
    return (t == TIMER_MAX) ? TIMER_MAX : t + 1'b1;
  endfunction

  logic               enable;
  logic [PeriodW-1:0] flash_period;
  logic [PeriodW-1:0] update_period;

  logic [TimerW-1:0]  one_flash_timer;
  logic [TimerW-1:0]  two_flash_timer;
  logic [TimerW-1:0]  send_timer;
  logic               one_flash_phase;
  logic               two_flash_phase;
  logic [ShownW-1:0]  one_shown_value;
  logic [ShownW-1:0]  two_shown_value;

  logic                in_valid;
  logic [InDataW-1:0]  in_data;
  logic                out_valid;
  logic [OutDataW-1:0] out_data;

  logic               advance;
  logic [ScoreW-1:0]  s1;
  logic [ScoreW-1:0]  s2;
  logic [ModeW-1:0]   m1;
  logic [ModeW-1:0]   m2;
  logic               sync;
  logic [TimerW-1:0]  one_timer_inc;
  logic [TimerW-1:0]  two_timer_inc;
  logic [TimerW-1:0]  send_inc;
  logic               one_phase_base;
  logic               two_phase_base;
  player_t            one_upd;
  player_t            two_upd;
  player_t            one_next;
  player_t            two_next;
  logic               emit;
  logic [TimerW-1:0]  send_timer_next;
  seg3_t              enc1;
  seg3_t              enc2;
  logic [OutDataW-1:0] out_data_next;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  assign s1   = in_data[15:0];
  assign s2   = in_data[31:16];
  assign m1   = in_data[33:32];
  assign m2   = in_data[35:34];
  assign sync = in_data[36];

  always_comb begin
    one_timer_inc  = tick(sync ? '0 : one_flash_timer);
    two_timer_inc  = tick(sync ? '0 : two_flash_timer);
    send_inc       = tick(send_timer);
    one_phase_base = sync ? 1'b0 : one_flash_phase;
    two_phase_base = sync ? 1'b0 : two_flash_phase;
    one_upd = player_update(m1, s1, one_timer_inc, one_phase_base, one_shown_value,
                            flash_period);
    two_upd = player_update(m2, s2, two_timer_inc, two_phase_base, two_shown_value,
                            flash_period);
    if (enable) begin
      one_next = one_upd;
      two_next = two_upd;
    end else begin
      one_next = '{timer: one_timer_inc, phase: one_phase_base, shown: one_shown_value};
      two_next = '{timer: two_timer_inc, phase: two_phase_base, shown: two_shown_value};
    end
    emit            = enable && (send_inc > {1'b0, update_period});
    send_timer_next = emit ? '0 : send_inc;
    enc1 = encode3(one_next.shown);
    enc2 = encode3(two_next.shown);
    out_data_next = {enc2.ones, enc2.tens, enc2.hund, enc1.ones, enc1.tens, enc1.hund};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      flash_period  <= FLASH_RST;
      update_period <= UPDATE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE:        enable        <= cfg_data[0];
        CFG_FLASH_PERIOD:  flash_period  <= cfg_data;
        CFG_UPDATE_PERIOD: update_period <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      one_flash_timer <= '0;
      two_flash_timer <= '0;
      send_timer      <= '0;
      one_flash_phase <= 1'b0;
      two_flash_phase <= 1'b0;
      one_shown_value <= '0;
      two_shown_value <= '0;
    end else if (advance) begin
      one_flash_timer <= one_next.timer;
      two_flash_timer <= two_next.timer;
      send_timer      <= send_timer_next;
      one_flash_phase <= one_next.phase;
      two_flash_phase <= two_next.phase;
      one_shown_value <= one_next.shown;
      two_shown_value <= two_next.shown;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_data <= out_data_next;
    end
  end

endmodule

// ----- hdl/sdfe_checker.sv -----
module sdfe_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sdfe_pkg::OutDataW-1:0] m_axis_tdata
);

  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result dropped or changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a stalled result");

  a_seg_msb: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !m_axis_tdata[7] && !m_axis_tdata[15] && !m_axis_tdata[23] &&
                      !m_axis_tdata[31] && !m_axis_tdata[39] && !m_axis_tdata[47])
    else $error("segment byte with top bit set");

  a_p1_blank: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[7:0] == '0 && m_axis_tdata[15:8] != '0 |->
      m_axis_tdata[15:8] != 8'h3F)
    else $error("leading zero tens digit not blanked");

endmodule

bind score_display_flash_encoder_top sdfe_checker u_sdfe_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

typedef struct packed {
  logic [2:0]                   pad;
  logic                         sync_flash;
  sdfe_pkg::mode_t              p2_mode;
  sdfe_pkg::mode_t              p1_mode;
  logic [sdfe_pkg::ScoreW-1:0]  p2_score;
  logic [sdfe_pkg::ScoreW-1:0]  p1_score;
} request_t;

typedef struct packed {
  logic [sdfe_pkg::WordW-1:0] right_word;
  logic [sdfe_pkg::WordW-1:0] middle_word;
  logic [sdfe_pkg::WordW-1:0] left_word;
} frame_t;

class frame_scoreboard;
  logic                         en_reg;
  logic [sdfe_pkg::PeriodW-1:0] flash_len;
  logic [sdfe_pkg::PeriodW-1:0] update_len;
  logic [sdfe_pkg::TimerW-1:0]  p1_timer;
  logic [sdfe_pkg::TimerW-1:0]  p2_timer;
  logic [sdfe_pkg::TimerW-1:0]  frame_timer;
  logic                         p1_phase;
  logic                         p2_phase;
  logic [sdfe_pkg::ShownW-1:0]  p1_value;
  logic [sdfe_pkg::ShownW-1:0]  p2_value;
  frame_t                       expected_frames[$];
  int                           fail_count;

  function new();
    en_reg      = 1'b0;
    flash_len   = sdfe_pkg::FLASH_RST;
    update_len  = sdfe_pkg::UPDATE_RST;
    p1_timer    = '0;
    p2_timer    = '0;
    frame_timer = '0;
    p1_phase    = 1'b0;
    p2_phase    = 1'b0;
    p1_value    = '0;
    p2_value    = '0;
    fail_count  = 0;
  endfunction

  function int pending();
    return expected_frames.size();
  endfunction

  function void write_reg(logic [sdfe_pkg::CfgIdxW-1:0] idx, logic [sdfe_pkg::CfgW-1:0] data);
    case (idx)
      sdfe_pkg::CFG_ENABLE:        en_reg = data[0];
      sdfe_pkg::CFG_FLASH_PERIOD:  flash_len = data;
      sdfe_pkg::CFG_UPDATE_PERIOD: update_len = data;
      default: ;
    endcase
  endfunction

  function logic [sdfe_pkg::TimerW-1:0] bump(logic [sdfe_pkg::TimerW-1:0] t);
    return (t == sdfe_pkg::TIMER_MAX) ? t : t + 1'b1;
  endfunction

  function void advance_player(sdfe_pkg::mode_t mode, logic [sdfe_pkg::ScoreW-1:0] score,
                               inout logic [sdfe_pkg::TimerW-1:0] timer,
                               inout logic phase, inout logic [sdfe_pkg::ShownW-1:0] shown);
    if (mode == sdfe_pkg::MODE_FLASH) begin
      if (timer > {1'b0, flash_len}) begin
        timer = '0;
        if (!phase) begin
          phase = 1'b1;
          shown = (score > sdfe_pkg::SCORE_MAX) ? sdfe_pkg::BLANK_CODE : score[9:0];
        end else begin
          phase = 1'b0;
          shown = sdfe_pkg::BLANK_CODE;
        end
      end
    end else if (mode == sdfe_pkg::MODE_BLANK) begin
      shown = sdfe_pkg::BLANK_CODE;
    end else begin
      shown = (score > sdfe_pkg::SCORE_MAX) ? sdfe_pkg::SCORE_MAX : score[9:0];
    end
  endfunction

  function logic [sdfe_pkg::SegW-1:0] digit_segments(int unsigned d);
    case (d)
      0: return 8'h3F;
      1: return 8'h06;
      2: return 8'h5B;
      3: return 8'h4F;
      4: return 8'h66;
      5: return 8'h6D;
      6: return 8'h7D;
      7: return 8'h07;
      8: return 8'h7F;
      9: return 8'h6F;
      default: return 8'h00;
    endcase
  endfunction

  function sdfe_pkg::seg3_t encode_digits(logic [sdfe_pkg::ShownW-1:0] v);
    sdfe_pkg::seg3_t s;
    int unsigned n;
    n = v;
    s = '0;
    if (v > sdfe_pkg::SCORE_MAX) return s;
    s.ones = digit_segments(n % 10);
    s.tens = digit_segments((n / 10) % 10);
    s.hund = digit_segments((n / 100) % 10);
    if (n < 100) s.hund = '0;
    if (n < 10) s.tens = '0;
    return s;
  endfunction

  function void note_request(request_t req);
    sdfe_pkg::seg3_t d1;
    sdfe_pkg::seg3_t d2;
    frame_t f;
    if (req.sync_flash) begin
      p1_timer = '0;
      p2_timer = '0;
      p1_phase = 1'b0;
      p2_phase = 1'b0;
    end
    p1_timer    = bump(p1_timer);
    p2_timer    = bump(p2_timer);
    frame_timer = bump(frame_timer);
    if (!en_reg) return;
    advance_player(req.p1_mode, req.p1_score, p1_timer, p1_phase, p1_value);
    advance_player(req.p2_mode, req.p2_score, p2_timer, p2_phase, p2_value);
    if (frame_timer <= {1'b0, update_len}) return;
    frame_timer = '0;
    d1 = encode_digits(p1_value);
    d2 = encode_digits(p2_value);
    f.left_word   = {d1.tens, d1.hund};
    f.middle_word = {d2.hund, d1.ones};
    f.right_word  = {d2.ones, d2.tens};
    expected_frames.push_back(f);
  endfunction

  function void compare_word(string what, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch %s: expected %h, got %h", what, want, got);
    end
  endfunction

  function void check_frame(frame_t got);
    frame_t want;
    if (expected_frames.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch: frame %h with none expected", got);
      return;
    end
    want = expected_frames.pop_front();
    compare_word("left_word", want.left_word, got.left_word);
    compare_word("middle_word", want.middle_word, got.middle_word);
    compare_word("right_word", want.right_word, got.right_word);
  endfunction
endclass

module tb_top;
  import sdfe_pkg::*;

  localparam int LIMIT = 200000;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgW-1:0]     cfg_data;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  frame_scoreboard sb;
  int              idle_mode;
  int              cycle_count;

  score_display_flash_encoder_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_frame(frame_t'(m_axis_tdata));
    case (idle_mode)
      2: m_axis_tready <= ($urandom_range(99) >= 46);
      3: m_axis_tready <= ($urandom_range(99) >= 28);
      default: m_axis_tready <= 1'b1;
    endcase
  end

  function automatic bit sender_idles();
    case (idle_mode)
      1: return $urandom_range(99) < 46;
      3: return $urandom_range(99) < 28;
      default: return 1'b0;
    endcase
  endfunction

  function automatic request_t make_req(int s1, int s2, mode_t m1, mode_t m2, bit sync);
    request_t r;
    r.pad        = '0;
    r.sync_flash = sync;
    r.p2_mode    = m2;
    r.p1_mode    = m1;
    r.p2_score   = s2[15:0];
    r.p1_score   = s1[15:0];
    return r;
  endfunction

  function automatic int pick_score();
    case ($urandom_range(5))
      0: return $urandom_range(9);
      1: return $urandom_range(1001, 995);
      2: return 65535;
      3: return $urandom_range(999);
      default: return $urandom_range(65535);
    endcase
  endfunction

  function automatic mode_t pick_mode();
    if ($urandom_range(1)) return MODE_FLASH;
    return mode_t'($urandom_range(3));
  endfunction

  task automatic send_request(request_t req);
    if (sender_idles()) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while (sender_idles());
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(req);
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic set_config(bit en, int flash, int upd);
    hold_until_drained();
    repeat (6) @(posedge clk);
    write_reg(CFG_ENABLE, {7'($urandom_range(127)), en});
    write_reg(CFG_FLASH_PERIOD, flash[7:0]);
    write_reg(CFG_UPDATE_PERIOD, upd[7:0]);
    write_reg(2'd3, 8'($urandom_range(255)));
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(bit en, int flash, int upd, int mode, int n, int sync_pct,
                           int hold_at);
    set_config(en, flash, upd);
    idle_mode = mode;
    for (int k = 0; k < n; k++) begin
      if (k == hold_at) hold_until_drained();
      send_request(make_req(pick_score(), pick_score(), pick_mode(), pick_mode(),
                            $urandom_range(99) < sync_pct));
    end
  endtask

  initial begin
    sb            = new();
    idle_mode     = 0;
    cycle_count   = 0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // disabled after reset: timers run, nothing is sent
    send_request(make_req(123, 456, MODE_NORMAL, MODE_NORMAL, 1'b0));
    send_request(make_req(65535, 0, MODE_FLASH, MODE_BLANK, 1'b1));
    send_request(make_req(7, 999, MODE_ALT, MODE_FLASH, 1'b0));

    set_config(1'b1, 0, 0);
    send_request(make_req(0, 0, MODE_NORMAL, MODE_NORMAL, 1'b0));
    send_request(make_req(5, 7, MODE_NORMAL, MODE_NORMAL, 1'b0));
    send_request(make_req(10, 100, MODE_NORMAL, MODE_NORMAL, 1'b0));
    send_request(make_req(999, 1000, MODE_NORMAL, MODE_NORMAL, 1'b0));
    send_request(make_req(65535, 0, MODE_NORMAL, MODE_ALT, 1'b0));
    send_request(make_req(42, 65535, MODE_ALT, MODE_ALT, 1'b0));
    send_request(make_req(321, 654, MODE_BLANK, MODE_BLANK, 1'b0));
    send_request(make_req(1500, 123, MODE_FLASH, MODE_FLASH, 1'b1));
    send_request(make_req(1500, 123, MODE_FLASH, MODE_FLASH, 1'b0));
    send_request(make_req(1000, 90, MODE_FLASH, MODE_FLASH, 1'b0));
    send_request(make_req(1000, 90, MODE_FLASH, MODE_FLASH, 1'b0));
    send_request(make_req(88, 808, MODE_FLASH, MODE_NORMAL, 1'b1));
    send_request(make_req(88, 808, MODE_NORMAL, MODE_FLASH, 1'b0));
    send_request(make_req(65535, 65535, MODE_FLASH, MODE_FLASH, 1'b0));
    send_request(make_req(1, 9, MODE_BLANK, MODE_NORMAL, 1'b0));

    set_config(1'b1, 255, 255);
    send_request(make_req(500, 50, MODE_FLASH, MODE_FLASH, 1'b0));
    send_request(make_req(501, 51, MODE_NORMAL, MODE_FLASH, 1'b0));

    run_phase(1'b1, FLASH_RST, UPDATE_RST, 0, 40, 10, -1);
    run_phase(1'b1, 0, 0, 1, 40, 12, 20);
    run_phase(1'b1, 3, 2, 2, 40, 12, -1);
    run_phase(1'b1, 255, 0, 3, 60, 0, -1);
    run_phase(1'b0, 7, 0, 3, 20, 12, -1);
    run_phase(1'b1, $urandom_range(12, 1), 255, 1, 140, 1, -1);
    run_phase(1'b1, $urandom_range(12, 1), $urandom_range(4), 2, 30, 12, -1);
    run_phase(1'b1, 1, 0, 3, 30, 15, -1);
    run_phase(1'b1, $urandom_range(255), $urandom_range(255), 0, 10, 12, -1);

    hold_until_drained();
    repeat (8) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule
